FILE: sv/link_frame_receiver_top_macros.svh
// Assertion macros for the link frame receiver top level.
`ifndef LINK_FRAME_RECEIVER_TOP_MACROS_SVH
`define LINK_FRAME_RECEIVER_TOP_MACROS_SVH

// Checked property, disabled while reset is asserted
`define LFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked property, also checked during reset
`define LFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/lfr_pkg.sv
// Package for the link frame receiver: frame characters, codes and result type.
package lfr_pkg;

  // Frame characters
  localparam logic [7:0] ChC     = 8'h43;  // 'C'
  localparam logic [7:0] ChX     = 8'h58;  // 'X'
  localparam logic [7:0] ChN     = 8'h4E;  // 'N'
  localparam logic [7:0] ChD     = 8'h44;  // 'D'
  localparam logic [7:0] ChT     = 8'h54;  // 'T'
  localparam logic [7:0] ChF     = 8'h46;  // 'F'
  localparam logic [7:0] ChTrBnd = 8'h34;  // '4', bind and unbind trailer
  localparam logic [7:0] ChTrCnt = 8'h36;  // '6', control frame trailer
  localparam logic [7:0] ChTrCnf = 8'h37;  // '7', config frame trailer

  // Frame positions
  localparam logic [2:0] Pos0 = 3'd0;
  localparam logic [2:0] Pos1 = 3'd1;
  localparam logic [2:0] Pos2 = 3'd2;
  localparam logic [2:0] Pos3 = 3'd3;
  localparam logic [2:0] Pos4 = 3'd4;
  localparam logic [2:0] Pos5 = 3'd5;
  localparam logic [2:0] Pos6 = 3'd6;
  localparam logic [2:0] Pos7 = 3'd7;

  typedef enum logic [1:0] {
    KIND_C = 2'd0,
    KIND_F = 2'd1,
    KIND_D = 2'd2
  } lfr_kind_e;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_CONN = 3'd1,
    EV_DISC = 3'd2,
    EV_CTRL = 3'd3,
    EV_CONF = 3'd4
  } lfr_event_e;

  typedef struct packed {
    lfr_event_e event_res;
    logic       link_up;
    logic [7:0] bound_address;
    logic [7:0] speed;
    logic [7:0] emergency_stop;
    logic [7:0] acceleration;
    logic [7:0] cable_length_first;
    logic [7:0] cable_length_second;
  } lfr_result_t;

endpackage

FILE: sv/link_frame_receiver_top.sv
// Link frame receiver top level: input register, frame parser, result register.
//
// Usage: one received byte per transfer on the input channel (in_valid_i,
// in_ready_o, rx_byte_i). Each byte gives exactly one result on the output
// channel (out_valid_o, out_ready_i and the result fields): the event code of
// a frame that completed on this byte, or none, together with the link state,
// bound address and the latched control and config fields after that byte.
// Path: a byte moves from the input register through the parser into the
// result register. Throughput: one byte per cycle while out_ready_i is high;
// the parser updates once per byte between the input and result registers.
// Reset: the link is unbound, the parser is at the frame start, its latched
// fields read zero and both channels are empty. No clearing pass is needed.
// Stall: while out_ready_i is low the result holds; one further byte waits in
// the input register, after which in_ready_o drops until the result is taken.
module link_frame_receiver_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                event_res_o,
  output logic                      link_up_o,
  output logic [7:0]                bound_address_o,
  output logic [7:0]                speed_o,
  output logic [7:0]                emergency_stop_o,
  output logic [7:0]                acceleration_o,
  output logic [7:0]                cable_length_first_o,
  output logic [7:0]                cable_length_second_o
);
  import lfr_pkg::*;

  `include "link_frame_receiver_top_macros.svh"

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        out_vld_q;
  lfr_result_t res;
  lfr_result_t res_q;
  logic        advance;

  // Byte moves into the parser when the result register can take its result
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  lfr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .rx_byte_i (in_byte_q),
    .res_o     (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o           = out_vld_q;
  assign event_res_o           = res_q.event_res;
  assign link_up_o             = res_q.link_up;
  assign bound_address_o       = res_q.bound_address;
  assign speed_o               = res_q.speed;
  assign emergency_stop_o      = res_q.emergency_stop;
  assign acceleration_o        = res_q.acceleration;
  assign cable_length_first_o  = res_q.cable_length_first;
  assign cable_length_second_o = res_q.cable_length_second;

  // Checks
  `LFR_ASSERT(a_conn_link_up, out_vld_q && res_q.event_res == EV_CONN |-> res_q.link_up, "connect event without link up")
  `LFR_ASSERT(a_disc_link_down, out_vld_q && res_q.event_res == EV_DISC |-> !res_q.link_up, "disconnect event with link up")
  `LFR_ASSERT(a_frame_needs_link, out_vld_q && (res_q.event_res == EV_CTRL || res_q.event_res == EV_CONF) |-> res_q.link_up, "frame accepted while unbound")
  `LFR_ASSERT(a_pending_moves, in_vld_q && !out_vld_q |=> out_vld_q, "pending byte not moved into result")
  `LFR_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !in_vld_q && !out_vld_q, "pipeline not empty in reset")

endmodule

FILE: sv/lfr_parser.sv
// Frame parser: link state, frame position and latched frame fields.
module lfr_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           rx_byte_i,
  output lfr_pkg::lfr_result_t res_o
);
  import lfr_pkg::*;

  logic [2:0] pos_q, pos_d;
  logic       conn_q, conn_d;
  logic [7:0] addr_q, addr_d;
  logic [1:0] kind_q, kind_d;
  logic [7:0] pay_q [3];
  logic [7:0] pay_d [3];
  logic [7:0] speed_q, speed_d;
  logic [7:0] estop_q, estop_d;
  logic [7:0] accel_q, accel_d;
  logic [7:0] cab0_q, cab0_d;
  logic [7:0] cab1_q, cab1_d;
  lfr_event_e ev;

  // Next state for one byte; a mismatch drops back to the frame start
  always_comb begin
    pos_d   = Pos0;
    conn_d  = conn_q;
    addr_d  = addr_q;
    kind_d  = kind_q;
    pay_d   = pay_q;
    speed_d = speed_q;
    estop_d = estop_q;
    accel_d = accel_q;
    cab0_d  = cab0_q;
    cab1_d  = cab1_q;
    ev      = EV_NONE;
    if (!conn_q) begin
      case (pos_q)
        Pos0: if (rx_byte_i == ChC) pos_d = Pos1;
        Pos1: if (rx_byte_i == ChX) pos_d = Pos2;
        Pos2: if (rx_byte_i == ChN) pos_d = Pos3;
        Pos3: begin
          pay_d[0] = rx_byte_i;
          pos_d    = Pos4;
        end
        Pos4: begin
          if (rx_byte_i == ChTrBnd) begin
            conn_d = 1'b1;
            addr_d = pay_q[0];
            ev     = EV_CONN;
          end
        end
        default: pos_d = Pos0;
      endcase
    end else begin
      case (pos_q)
        Pos0: begin
          if (rx_byte_i == ChC) begin
            kind_d = KIND_C;
            pos_d  = Pos1;
          end else if (rx_byte_i == ChD) begin
            kind_d = KIND_D;
            pos_d  = Pos1;
          end
        end
        Pos1: begin
          if ((kind_q == KIND_C && rx_byte_i == ChN) ||
              (kind_q == KIND_D && rx_byte_i == ChC)) pos_d = Pos2;
        end
        Pos2: begin
          if (kind_q == KIND_C && rx_byte_i == ChT) begin
            pos_d = Pos3;
          end else if (kind_q == KIND_C && rx_byte_i == ChF) begin
            kind_d = KIND_F;
            pos_d  = Pos3;
          end else if (kind_q == KIND_D && rx_byte_i == ChX) begin
            pos_d = Pos3;
          end
        end
        Pos3: if (rx_byte_i == addr_q) pos_d = Pos4;
        Pos4: begin
          if (kind_q == KIND_D) begin
            if (rx_byte_i == ChTrBnd) begin
              conn_d = 1'b0;
              ev     = EV_DISC;
            end
          end else if (kind_q == KIND_C || kind_q == KIND_F) begin
            pay_d[0] = rx_byte_i;
            pos_d    = Pos5;
          end
        end
        Pos5: begin
          pay_d[1] = rx_byte_i;
          pos_d    = Pos6;
        end
        Pos6: begin
          if (kind_q == KIND_C) begin
            if (rx_byte_i == ChTrCnt) begin
              speed_d = pay_q[0];
              estop_d = pay_q[1];
              ev      = EV_CTRL;
            end
          end else begin
            pay_d[2] = rx_byte_i;
            pos_d    = Pos7;
          end
        end
        default: begin
          if (kind_q == KIND_F && rx_byte_i == ChTrCnf) begin
            accel_d = pay_q[0];
            cab0_d  = pay_q[1];
            cab1_d  = pay_q[2];
            ev      = EV_CONF;
          end
        end
      endcase
    end
  end

  // Control state and latched outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= Pos0;
      conn_q  <= 1'b0;
      addr_q  <= 8'd0;
      speed_q <= 8'd0;
      estop_q <= 8'd0;
      accel_q <= 8'd0;
      cab0_q  <= 8'd0;
      cab1_q  <= 8'd0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      conn_q  <= conn_d;
      addr_q  <= addr_d;
      speed_q <= speed_d;
      estop_q <= estop_d;
      accel_q <= accel_d;
      cab0_q  <= cab0_d;
      cab1_q  <= cab1_d;
    end
  end

  // Frame kind and payload bytes: always written before being read
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      kind_q <= kind_d;
      pay_q  <= pay_d;
    end
  end

  // Result shows the state after this byte
  assign res_o.event_res           = ev;
  assign res_o.link_up             = conn_d;
  assign res_o.bound_address       = addr_d;
  assign res_o.speed               = speed_d;
  assign res_o.emergency_stop      = estop_d;
  assign res_o.acceleration        = accel_d;
  assign res_o.cable_length_first  = cab0_d;
  assign res_o.cable_length_second = cab1_d;

endmodule

FILE: dv/lfr_frame_checker.sv
// Link frame receiver checker: predicts each byte's link state and compares results.
`timescale 1ns / 1ps

module lfr_frame_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] rx_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [2:0] event_res_i,
  input  logic       link_up_i,
  input  logic [7:0] bound_address_i,
  input  logic [7:0] speed_i,
  input  logic [7:0] emergency_stop_i,
  input  logic [7:0] acceleration_i,
  input  logic [7:0] cable_length_first_i,
  input  logic [7:0] cable_length_second_i,
  output int         mismatch_count_o,
  output int         outstanding_o
);
  import lfr_pkg::*;

  localparam int ReportLimit = 10;

  // Predicted parser state
  logic [2:0] frame_pos;
  logic       linked;
  logic [7:0] peer_addr;
  lfr_kind_e  kind;
  logic [7:0] held [3];
  logic [7:0] spd, estp, accl, cab0, cab1;

  lfr_result_t predicted_link_q [$];
  int          mismatches;

  // Advance the predicted parser by one byte, return the completed frame event
  function automatic lfr_event_e parse_link_byte(logic [7:0] b);
    lfr_event_e ev;
    logic [2:0] at;
    ev        = EV_NONE;
    at        = frame_pos;
    frame_pos = Pos0;  // any byte that does not fit is consumed
    if (!linked) begin
      case (at)
        Pos0: if (b == ChC) frame_pos = Pos1;
        Pos1: if (b == ChX) frame_pos = Pos2;
        Pos2: if (b == ChN) frame_pos = Pos3;
        Pos3: begin
          held[0]   = b;
          frame_pos = Pos4;
        end
        Pos4: if (b == ChTrBnd) begin
          linked    = 1'b1;
          peer_addr = held[0];
          ev        = EV_CONN;
        end
        default: ;
      endcase
    end else begin
      case (at)
        Pos0: if (b == ChC) begin
          kind      = KIND_C;
          frame_pos = Pos1;
        end else if (b == ChD) begin
          kind      = KIND_D;
          frame_pos = Pos1;
        end
        Pos1: if ((kind == KIND_C && b == ChN) || (kind == KIND_D && b == ChC)) frame_pos = Pos2;
        Pos2: if (kind == KIND_C && b == ChT) begin
          frame_pos = Pos3;
        end else if (kind == KIND_C && b == ChF) begin
          kind      = KIND_F;
          frame_pos = Pos3;
        end else if (kind == KIND_D && b == ChX) begin
          frame_pos = Pos3;
        end
        Pos3: if (b == peer_addr) frame_pos = Pos4;
        Pos4: if (kind == KIND_D) begin
          if (b == ChTrBnd) begin
            linked = 1'b0;
            ev     = EV_DISC;
          end
        end else begin
          held[0]   = b;
          frame_pos = Pos5;
        end
        Pos5: begin
          held[1]   = b;
          frame_pos = Pos6;
        end
        Pos6: if (kind == KIND_C) begin
          if (b == ChTrCnt) begin
            spd  = held[0];
            estp = held[1];
            ev   = EV_CTRL;
          end
        end else begin
          held[2]   = b;
          frame_pos = Pos7;
        end
        default: if (kind == KIND_F && b == ChTrCnf) begin
          accl = held[0];
          cab0 = held[1];
          cab1 = held[2];
          ev   = EV_CONF;
        end
      endcase
    end
    return ev;
  endfunction

  function automatic string describe(lfr_result_t r);
    return $sformatf("ev=%0d up=%0d addr=%02h spd=%02h estop=%02h accel=%02h cable=%02h/%02h",
                     r.event_res, r.link_up, r.bound_address, r.speed, r.emergency_stop,
                     r.acceleration, r.cable_length_first, r.cable_length_second);
  endfunction

  // Track both channels: compare each result transfer, predict each byte transfer
  always @(posedge clk_i or negedge rst_ni) begin
    lfr_result_t seen;
    lfr_result_t due;
    if (!rst_ni) begin
      frame_pos = Pos0;
      linked    = 1'b0;
      peer_addr = '0;
      kind      = KIND_C;
      held      = '{default: '0};
      spd       = '0;
      estp      = '0;
      accl      = '0;
      cab0      = '0;
      cab1      = '0;
      mismatches = 0;
      predicted_link_q.delete();
      outstanding_o    <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen.event_res           = lfr_event_e'(event_res_i);
        seen.link_up             = link_up_i;
        seen.bound_address       = bound_address_i;
        seen.speed               = speed_i;
        seen.emergency_stop      = emergency_stop_i;
        seen.acceleration        = acceleration_i;
        seen.cable_length_first  = cable_length_first_i;
        seen.cable_length_second = cable_length_second_i;
        if (predicted_link_q.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("%t: result with nothing pending: %s", $realtime, describe(seen));
        end else begin
          due = predicted_link_q.pop_front();
          if (seen.event_res !== due.event_res || seen.link_up !== due.link_up ||
              seen.bound_address !== due.bound_address || seen.speed !== due.speed ||
              seen.emergency_stop !== due.emergency_stop ||
              seen.acceleration !== due.acceleration ||
              seen.cable_length_first !== due.cable_length_first ||
              seen.cable_length_second !== due.cable_length_second) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("%t: expected %s", $realtime, describe(due));
              $display("%t: actual   %s", $realtime, describe(seen));
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        due.event_res           = parse_link_byte(rx_byte_i);
        due.link_up             = linked;
        due.bound_address       = peer_addr;
        due.speed               = spd;
        due.emergency_stop      = estp;
        due.acceleration        = accl;
        due.cable_length_first  = cab0;
        due.cable_length_second = cab1;
        predicted_link_q.push_back(due);
      end
      outstanding_o    <= predicted_link_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

FILE: dv/tb_link_frame_receiver_top.sv
// Testbench top for the link frame receiver: frame stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module tb_link_frame_receiver_top;
  import lfr_pkg::*;

  typedef enum logic [1:0] {
    FR_BIND,
    FR_UNBIND,
    FR_CTRL,
    FR_CONF
  } frame_shape_e;

  localparam int         TotalBytes = 935;
  localparam logic [7:0] FlushByte  = 8'h5A;  // 'Z': fits no frame character
  localparam int         FlushLen   = 8;      // enough to return from any position

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [2:0] event_res_o;
  logic       link_up_o;
  logic [7:0] bound_address_o;
  logic [7:0] speed_o;
  logic [7:0] emergency_stop_o;
  logic [7:0] acceleration_o;
  logic [7:0] cable_length_first_o;
  logic [7:0] cable_length_second_o;

  int         mismatch_count;
  int         outstanding;
  int         bytes_sent;
  bit         steady_flow;     // no idling on either side while set
  bit         link_believed;   // stimulus-side guess of the link state
  logic [7:0] addr_believed;
  logic [7:0] frame_q [$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  link_frame_receiver_top u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .rx_byte_i             (rx_byte_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .event_res_o           (event_res_o),
    .link_up_o             (link_up_o),
    .bound_address_o       (bound_address_o),
    .speed_o               (speed_o),
    .emergency_stop_o      (emergency_stop_o),
    .acceleration_o        (acceleration_o),
    .cable_length_first_o  (cable_length_first_o),
    .cable_length_second_o (cable_length_second_o)
  );

  lfr_frame_checker u_checker (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_ready_i            (in_ready_o),
    .rx_byte_i             (rx_byte_i),
    .out_valid_i           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .event_res_i           (event_res_o),
    .link_up_i             (link_up_o),
    .bound_address_i       (bound_address_o),
    .speed_i               (speed_o),
    .emergency_stop_i      (emergency_stop_o),
    .acceleration_i        (acceleration_o),
    .cable_length_first_i  (cable_length_first_o),
    .cable_length_second_i (cable_length_second_o),
    .mismatch_count_o      (mismatch_count),
    .outstanding_o         (outstanding)
  );

  // Result side stalls about a third of the time
  always @(negedge clk_i) begin
    out_ready_i <= steady_flow || ($urandom_range(0, 99) >= 33);
  end

  // One byte transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while (!steady_flow && $urandom_range(0, 99) < 33) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic flush_parser();
    repeat (FlushLen) send_byte(FlushByte);
  endtask

  task automatic load_frame(input frame_shape_e shape, input logic [7:0] addr,
                            input logic [7:0] p0, input logic [7:0] p1, input logic [7:0] p2);
    case (shape)
      FR_BIND:   frame_q = '{ChC, ChX, ChN, addr, ChTrBnd};
      FR_UNBIND: frame_q = '{ChD, ChC, ChX, addr, ChTrBnd};
      FR_CTRL:   frame_q = '{ChC, ChN, ChT, addr, p0, p1, ChTrCnt};
      default:   frame_q = '{ChC, ChN, ChF, addr, p0, p1, p2, ChTrCnf};
    endcase
  endtask

  // Send the loaded frame and follow the bind state it should leave
  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i]);
    if (frame_q.size() == 5 && frame_q[4] == ChTrBnd) begin
      if (!link_believed && frame_q[0] == ChC && frame_q[1] == ChX && frame_q[2] == ChN) begin
        link_believed = 1'b1;
        addr_believed = frame_q[3];
      end else if (link_believed && frame_q[0] == ChD && frame_q[1] == ChC &&
                   frame_q[2] == ChX && frame_q[3] == addr_believed) begin
        link_believed = 1'b0;
      end
    end
  endtask

  // Hold the sender until every pending result has been taken
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (outstanding == 0);
  endtask

  initial begin
    #5_000_000;
    $display("link_frame_receiver_top: mismatch");
    $finish;
  end

  initial begin
    frame_shape_e shape;
    int           roll;
    bit           paused;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    rx_byte_i     = '0;
    out_ready_i   = 1'b0;
    bytes_sent    = 0;
    steady_flow   = 1'b0;
    link_believed = 1'b0;
    addr_believed = '0;
    paused        = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: bind at the top address, extreme payloads, address mismatch, unbind
    load_frame(FR_BIND, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_frame();
    load_frame(FR_CTRL, 8'hFF, 8'hFF, 8'h00, 8'h00);
    send_frame();
    load_frame(FR_CONF, 8'hFF, 8'h00, 8'hFF, 8'h80);
    send_frame();
    frame_q = '{ChD, ChC, ChX, 8'h00};
    send_frame();
    load_frame(FR_UNBIND, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_frame();
    drain_results();

    // Random: mostly well-formed frames, some broken frames and line noise
    while (bytes_sent < TotalBytes) begin
      steady_flow = (bytes_sent >= 400 && bytes_sent < 550);
      if (!paused && bytes_sent >= 700) begin
        drain_results();
        paused = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        if (!link_believed) begin
          shape = FR_BIND;
        end else begin
          roll  = $urandom_range(0, 99);
          shape = (roll < 15) ? FR_UNBIND : (roll < 55) ? FR_CTRL : FR_CONF;
        end
        load_frame(shape, link_believed ? addr_believed : 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
        send_frame();
      end else if (roll < 85) begin
        // Broken frame: any shape in any link state, one byte flipped or tail cut off
        shape = frame_shape_e'($urandom_range(0, 3));
        load_frame(shape, link_believed ? addr_believed : 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) begin
          roll = $urandom_range(0, frame_q.size() - 1);
          frame_q[roll] = frame_q[roll] ^ 8'($urandom_range(1, 255));
        end else begin
          roll = $urandom_range(1, frame_q.size() - 1);
          while (frame_q.size() > roll) void'(frame_q.pop_back());
        end
        send_frame();
        flush_parser();
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        flush_parser();
      end
    end

    // Let the pipeline empty, then give the verdict
    @(negedge clk_i);
    in_valid_i  = 1'b0;
    steady_flow = 1'b0;
    wait (outstanding == 0);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("link_frame_receiver_top: match");
    end else begin
      $display("link_frame_receiver_top: mismatch");
    end
    $finish;
  end

endmodule
